[design/sbr_pkg.sv]
// Shared types, constants and register indexes for the stepped bias regulator.
// No dependencies; used by sbr_step and stepped_bias_regulator_top.
`default_nettype none

package sbr_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int DRIVE_BITS  = 12;
  localparam int REG_BITS    = 12;
  localparam int CFG_IDX_BITS = 3;

  localparam int CMP_BITS = (SAMPLE_BITS > REG_BITS) ? SAMPLE_BITS : REG_BITS;
  localparam int DRV_EXT_BITS = ((DRIVE_BITS > REG_BITS) ? DRIVE_BITS : REG_BITS) + 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TARGET_LEVEL = 3'd0,
    REG_DEAD_BAND    = 3'd1,
    REG_SMALL_BAND   = 3'd2,
    REG_MEDIUM_BAND  = 3'd3,
    REG_STABLE_LIMIT = 3'd4,
    REG_DRIVE_MIN    = 3'd5,
    REG_DRIVE_MAX    = 3'd6
  } reg_idx_t;

  localparam logic [REG_BITS-1:0] RST_TARGET_LEVEL = 12'd2048;
  localparam logic [REG_BITS-1:0] RST_DEAD_BAND    = 12'd62;
  localparam logic [REG_BITS-1:0] RST_SMALL_BAND   = 12'd124;
  localparam logic [REG_BITS-1:0] RST_MEDIUM_BAND  = 12'd372;
  localparam logic [REG_BITS-1:0] RST_STABLE_LIMIT = 12'd100;
  localparam logic [REG_BITS-1:0] RST_DRIVE_MIN    = 12'd0;
  localparam logic [REG_BITS-1:0] RST_DRIVE_MAX    = 12'd4095;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_SET  = 1'b1;

  localparam logic [2:0] IVL_SLOW = 3'd5;
  localparam logic [2:0] IVL_MID  = 3'd2;
  localparam logic [2:0] IVL_FAST = 3'd1;

  localparam logic [1:0] STEP_SLOW = 2'd1;
  localparam logic [1:0] STEP_MID  = 2'd2;
  localparam logic [1:0] STEP_FAST = 2'd3;

  typedef struct packed {
    logic [REG_BITS-1:0] target_level;
    logic [REG_BITS-1:0] dead_band;
    logic [REG_BITS-1:0] small_band;
    logic [REG_BITS-1:0] medium_band;
    logic [REG_BITS-1:0] stable_limit;
    logic [REG_BITS-1:0] drive_min;
    logic [REG_BITS-1:0] drive_max;
  } cfg_t;

  typedef struct packed {
    logic [2:0]             tick_count;
    logic [2:0]             tick_interval;
    logic [SAMPLE_BITS-1:0] hist0;
    logic [SAMPLE_BITS-1:0] hist1;
    logic [SAMPLE_BITS-1:0] hist2;
    logic [DRIVE_BITS-1:0]  drive_code;
  } state_t;

  typedef struct packed {
    logic [DRIVE_BITS-1:0] drive_value;
    logic                  drive_write;
    logic                  out_of_range;
  } result_t;

endpackage

`default_nettype wire

[design/stepped_bias_regulator_top.sv]
// Top level of the stepped bias regulator: config registers, state, result skid.
// Depends on sbr_pkg and sbr_step.
//
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall  func, sample, set_value
//  out_     output     out_valid/out_stall drive_value, drive_write, out_of_range
//  cfg_     input      cfg_valid/cfg_ready index, wdata (always ready)
//
// One item per cycle unless in_stall; results are registered in out_r or skid_r.
// The whole step is one pass through sbr_step into the result register.
// A two-entry result buffer lets intake take one more item under out_stall;
// in_stall rises only when both entries hold undelivered items.
// Synchronous active-low reset: cfg defaults, state cleared, interval IVL_FAST.
`default_nettype none

module stepped_bias_regulator_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_func,
  input  wire logic [sbr_pkg::SAMPLE_BITS-1:0]   in_sample,
  input  wire logic [sbr_pkg::DRIVE_BITS-1:0]    in_set_value,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [sbr_pkg::DRIVE_BITS-1:0]         out_drive_value,
  output logic                                   out_drive_write,
  output logic                                   out_out_of_range,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [sbr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [sbr_pkg::REG_BITS-1:0]      cfg_wdata
);

  sbr_pkg::cfg_t    cfg_r;
  sbr_pkg::state_t  st_r, st_nxt;
  sbr_pkg::result_t res_nxt, out_r, skid_r;
  logic             out_valid_r, skid_valid_r;
  logic             in_acc, out_acc;

  sbr_step u_step (
    .cfg       (cfg_r),
    .st        (st_r),
    .func      (in_func),
    .sample    (in_sample),
    .set_value (in_set_value),
    .st_nxt    (st_nxt),
    .res       (res_nxt)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_acc   = out_valid_r && !out_stall;

  assign out_drive_value  = out_r.drive_value;
  assign out_drive_write  = out_r.drive_write;
  assign out_out_of_range = out_r.out_of_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_level <= sbr_pkg::RST_TARGET_LEVEL;
      cfg_r.dead_band    <= sbr_pkg::RST_DEAD_BAND;
      cfg_r.small_band   <= sbr_pkg::RST_SMALL_BAND;
      cfg_r.medium_band  <= sbr_pkg::RST_MEDIUM_BAND;
      cfg_r.stable_limit <= sbr_pkg::RST_STABLE_LIMIT;
      cfg_r.drive_min    <= sbr_pkg::RST_DRIVE_MIN;
      cfg_r.drive_max    <= sbr_pkg::RST_DRIVE_MAX;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sbr_pkg::REG_TARGET_LEVEL: cfg_r.target_level <= cfg_wdata;
        sbr_pkg::REG_DEAD_BAND:    cfg_r.dead_band    <= cfg_wdata;
        sbr_pkg::REG_SMALL_BAND:   cfg_r.small_band   <= cfg_wdata;
        sbr_pkg::REG_MEDIUM_BAND:  cfg_r.medium_band  <= cfg_wdata;
        sbr_pkg::REG_STABLE_LIMIT: cfg_r.stable_limit <= cfg_wdata;
        sbr_pkg::REG_DRIVE_MIN:    cfg_r.drive_min    <= cfg_wdata;
        sbr_pkg::REG_DRIVE_MAX:    cfg_r.drive_max    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.tick_count    <= 3'd0;
      st_r.tick_interval <= 3'd1;
      st_r.hist0         <= '0;
      st_r.hist1         <= '0;
      st_r.hist2         <= '0;
      st_r.drive_code    <= '0;
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_acc) begin
        if (skid_valid_r) begin
          out_r        <= skid_r;
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_r       <= res_nxt;
          out_valid_r <= in_acc;
        end
      end else if (in_acc) begin
        skid_r       <= res_nxt;
        skid_valid_r <= 1'b1;
      end
    end
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a head item");

  a_out_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_r)))
    else $error("stalled item changed or dropped");

  a_tick_below_interval: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.tick_count < st_r.tick_interval)
    else $error("tick counter passed its interval");

  a_interval_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.tick_interval == sbr_pkg::IVL_SLOW) || (st_r.tick_interval == sbr_pkg::IVL_MID) ||
    (st_r.tick_interval == sbr_pkg::IVL_FAST))
    else $error("illegal tick interval");

  a_dead_band_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.out_of_range) |-> out_r.drive_write)
    else $error("in-band item without drive write");

endmodule

`default_nettype wire

[design/sbr_step.sv]
// Next-state and result logic for one item of the stepped bias regulator.
// Purely combinational; depends on sbr_pkg.
`default_nettype none

module sbr_step (
  input  var sbr_pkg::cfg_t                      cfg,
  input  var sbr_pkg::state_t                    st,
  input  wire logic                              func,
  input  wire logic [sbr_pkg::SAMPLE_BITS-1:0]   sample,
  input  wire logic [sbr_pkg::DRIVE_BITS-1:0]    set_value,
  output sbr_pkg::state_t                        st_nxt,
  output sbr_pkg::result_t                       res
);

  localparam int CW = sbr_pkg::CMP_BITS;
  localparam int DW = sbr_pkg::DRV_EXT_BITS;

  logic [2:0]    tc_inc;
  logic          eval;
  logic [CW-1:0] d01, d12, lim, s_ext, t_ext, mag;
  logic          stable, below;
  logic [1:0]    step;
  logic [2:0]    ivl;
  logic [DW-1:0] drv, dmin, dmax, up_sum, dn_floor;
  logic [DW-1:0] drv_new;

  always_comb begin
    tc_inc = st.tick_count + 3'd1;
    eval   = (func == sbr_pkg::FUNC_TICK) && (tc_inc >= st.tick_interval);

    d01 = (sample > st.hist0) ? CW'(sample - st.hist0) : CW'(st.hist0 - sample);
    d12 = (st.hist0 > st.hist1) ? CW'(st.hist0 - st.hist1) : CW'(st.hist1 - st.hist0);
    lim = CW'(cfg.stable_limit);
    stable = (d01 <= lim) && (d12 <= lim);

    s_ext = CW'(sample);
    t_ext = CW'(cfg.target_level);
    below = s_ext < t_ext;
    mag   = below ? (t_ext - s_ext) : (s_ext - t_ext);

    if (mag < CW'(cfg.small_band)) begin
      step = sbr_pkg::STEP_SLOW;
      ivl  = sbr_pkg::IVL_SLOW;
    end else if (mag < CW'(cfg.medium_band)) begin
      step = sbr_pkg::STEP_MID;
      ivl  = sbr_pkg::IVL_MID;
    end else begin
      step = sbr_pkg::STEP_FAST;
      ivl  = sbr_pkg::IVL_FAST;
    end

    drv      = DW'(st.drive_code);
    dmin     = DW'(cfg.drive_min);
    dmax     = DW'(cfg.drive_max);
    up_sum   = drv + DW'(step);
    dn_floor = dmin + DW'(step);

    st_nxt  = st;
    drv_new = drv;
    res.drive_write  = 1'b0;
    res.out_of_range = 1'b1;

    if (func == sbr_pkg::FUNC_SET) begin
      st_nxt.drive_code = set_value;
      res.drive_write   = 1'b1;
    end else if (!eval) begin
      st_nxt.tick_count = tc_inc;
    end else begin
      st_nxt.tick_count = 3'd0;
      st_nxt.hist2 = st.hist1;
      st_nxt.hist1 = st.hist0;
      st_nxt.hist0 = sample;
      if (stable) begin
        res.drive_write = 1'b1;
        if (below && (mag > CW'(cfg.dead_band))) begin
          if (drv < dmax) begin
            st_nxt.tick_interval = ivl;
            drv_new = (up_sum > dmax) ? dmax : up_sum;
          end
        end else if (!below && (mag > CW'(cfg.dead_band))) begin
          if (drv > dmin) begin
            st_nxt.tick_interval = ivl;
            drv_new = (drv < dn_floor) ? dmin : (drv - DW'(step));
          end
        end else begin
          res.out_of_range = 1'b0;
        end
        st_nxt.drive_code = drv_new[sbr_pkg::DRIVE_BITS-1:0];
      end
    end

    res.drive_value = st_nxt.drive_code;
  end

endmodule

`default_nettype wire
